FILE: sv/rc4_pkg.sv
// shared constants and codes for the rc4 stream cipher
`timescale 1ns / 1ps

package rc4_pkg;

    // byte and table geometry
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;

    // configuration port geometry
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;
    localparam int WORD_BYTES  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;

    // key length after reset
    localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 5'd16;

endpackage

FILE: sv/rc4_ram.sv
// generic simple dual port ram with registered read, read returns old data
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/rc4_stream_cipher_top.sv
// rc4 stream cipher: one permutation ram, key schedule and keystream sequencer
// a byte without the first flag runs P_RD_I, P_RD_J, P_RD_T, P_WR_J to the output register
// one byte at a time, set by the serial read/swap chain on the ram; P_WR_J waits out a stall
// a first-flag byte adds an identity fill, then K_RD_N, K_RD_A, K_WR_N, K_WR_A per table entry
// reset: control clears at once, then a fill sweep loads the identity permutation
// and no byte is accepted until it ends; configuration writes are taken at any time
`timescale 1ns / 1ps

module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rc4_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            first,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]      result_byte,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int BW     = rc4_pkg::BYTE_W;
    localparam int LW     = rc4_pkg::LEN_W;
    localparam int AW     = $clog2(rc4_pkg::TABLE_DEPTH);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int WB     = rc4_pkg::WORD_BYTES;

    typedef enum logic [3:0] {
        FILL,
        IDLE,
        K_RD_N,
        K_RD_A,
        K_WR_N,
        K_WR_A,
        P_RD_I,
        P_RD_J,
        P_RD_T,
        P_WR_J
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                ksa_pend_reg, ksa_pend_next;
    logic [KIDX_W-1:0]   kidx_reg, kidx_next;
    logic [BW-1:0]       i_reg, i_next;
    logic [BW-1:0]       j_reg, j_next;
    logic [BW-1:0]       hold_reg, hold_next;
    logic [BW-1:0]       sj_reg, sj_next;
    logic [BW-1:0]       t_reg, t_next;
    logic [BW-1:0]       data_reg, data_next;
    logic                out_valid_reg, out_valid_next;
    logic [BW-1:0]       result_byte_reg, result_byte_next;

    logic [LW-1:0]       key_length_reg;
    logic [BW-1:0]       key_reg [MAX_KEY_BYTES];

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [BW-1:0]       ram_rdata;

    logic [LW-1:0]       len_eff;
    logic                kidx_wrap;
    logic [BW-1:0]       key_cur;
    logic [BW-1:0]       acc_sum;
    logic [BW-1:0]       ks;
    logic                out_free;
    logic                cfg_we;

    // permutation table
    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (rc4_pkg::TABLE_DEPTH)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers, key bytes kept only up to the supported length
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= rc4_pkg::KEY_LENGTH_RESET;
            for (int b = 0; b < MAX_KEY_BYTES; b++)
            begin
                key_reg[b] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == rc4_pkg::CFG_KEY_LENGTH)
            begin
                key_length_reg <= cfg_data[LW-1:0];
            end
            for (int b = 0; b < MAX_KEY_BYTES; b++)
            begin
                if ((b < WB && cfg_index == rc4_pkg::CFG_KEY_LOW) ||
                    (b >= WB && cfg_index == rc4_pkg::CFG_KEY_HIGH))
                begin
                    key_reg[b] <= cfg_data[BW*(b & (WB-1)) +: BW];
                end
            end
        end
    end

    // effective key length, zero counts as one and long keys are clamped
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (key_length_reg > LW'(MAX_KEY_BYTES))
        begin
            len_eff = LW'(MAX_KEY_BYTES);
        end
        else
        begin
            len_eff = key_length_reg;
        end
    end

    assign kidx_wrap = (LW'(kidx_reg) == (len_eff - LW'(1)));
    assign key_cur   = key_reg[kidx_reg];
    assign acc_sum   = j_reg + ram_rdata + key_cur;

    // keystream byte, forwarding the two swap writes over the ram read
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks = hold_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else
        begin
            ks = ram_rdata;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != IDLE);

    // sequencer next state and ram control
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        ksa_pend_next    = ksa_pend_reg;
        kidx_next        = kidx_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        hold_next        = hold_reg;
        sj_next          = sj_reg;
        t_next           = t_reg;
        data_next        = data_reg;
        out_valid_next   = out_valid_reg && out_stall;
        result_byte_next = result_byte_reg;
        ram_we           = 1'b0;
        ram_waddr        = cnt_reg;
        ram_wdata        = cnt_reg;
        ram_raddr        = cnt_reg;

        unique case (state_reg)
            // identity fill sweep
            FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == AW'(rc4_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = ksa_pend_reg ? K_RD_N : IDLE;
                end
            end
            // wait for a byte
            IDLE:
            begin
                if (in_valid)
                begin
                    data_next = data_byte;
                    if (first)
                    begin
                        state_next    = FILL;
                        ksa_pend_next = 1'b1;
                        cnt_next      = '0;
                        kidx_next     = '0;
                        i_next        = '0;
                        j_next        = '0;
                    end
                    else
                    begin
                        state_next = P_RD_I;
                    end
                end
            end
            // key schedule: read s[n]
            K_RD_N:
            begin
                ram_raddr  = cnt_reg;
                state_next = K_RD_A;
            end
            // key schedule: update accumulator, read s[acc]
            K_RD_A:
            begin
                hold_next  = ram_rdata;
                j_next     = acc_sum;
                ram_raddr  = acc_sum;
                state_next = K_WR_N;
            end
            // key schedule: s[n] takes s[acc]
            K_WR_N:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_reg;
                ram_wdata  = ram_rdata;
                state_next = K_WR_A;
            end
            // key schedule: s[acc] takes old s[n]
            K_WR_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = hold_reg;
                cnt_next  = cnt_reg + 1'b1;
                kidx_next = kidx_wrap ? '0 : kidx_reg + 1'b1;
                if (cnt_reg == AW'(rc4_pkg::TABLE_DEPTH - 1))
                begin
                    ksa_pend_next = 1'b0;
                    j_next        = '0;
                    state_next    = P_RD_I;
                end
                else
                begin
                    state_next = K_RD_N;
                end
            end
            // keystream: step i, read s[i]
            P_RD_I:
            begin
                i_next     = i_reg + 1'b1;
                ram_raddr  = i_reg + 1'b1;
                state_next = P_RD_J;
            end
            // keystream: step j, read s[j]
            P_RD_J:
            begin
                hold_next  = ram_rdata;
                j_next     = j_reg + ram_rdata;
                ram_raddr  = j_reg + ram_rdata;
                state_next = P_RD_T;
            end
            // keystream: s[i] takes s[j], read s[s[i]+s[j]]
            P_RD_T:
            begin
                sj_next    = ram_rdata;
                t_next     = hold_reg + ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                ram_raddr  = hold_reg + ram_rdata;
                state_next = P_WR_J;
            end
            // keystream: s[j] takes old s[i], combine and hand off
            P_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = hold_reg;
                ram_raddr = t_reg;
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    result_byte_next = data_reg ^ ks;
                    state_next       = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FILL;
            cnt_reg       <= '0;
            ksa_pend_reg  <= 1'b0;
            kidx_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ksa_pend_reg  <= ksa_pend_next;
            kidx_reg      <= kidx_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg        <= hold_next;
        sj_reg          <= sj_next;
        t_reg           <= t_next;
        data_reg        <= data_next;
        result_byte_reg <= result_byte_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_byte_reg;

    // the table is left alone while waiting for a byte
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == IDLE |-> !ram_we)
        else $error("permutation table written while idle");

    // a byte without the first flag goes straight to the keystream step
    a_plain_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !first |=> state_reg == P_RD_I)
        else $error("plain byte did not start a keystream step");

    // key schedule leaves j cleared and moves on to the pending byte
    a_ksa_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == K_WR_A && cnt_reg == AW'(rc4_pkg::TABLE_DEPTH - 1)
        |=> state_reg == P_RD_I && j_reg == '0)
        else $error("key schedule did not hand over cleanly");

    // i advances by exactly one per keystream step
    a_i_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == P_RD_I |=> i_reg == $past(i_reg) + 8'd1)
        else $error("index i did not advance by one");

endmodule

FILE: tb/tb_rc4_stream_cipher_top.sv
// self-checking testbench for the rc4 stream cipher top level
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_top;

    localparam int BYTE_W      = rc4_pkg::BYTE_W;
    localparam int TABLE_DEPTH = rc4_pkg::TABLE_DEPTH;
    localparam int CFG_IDX_W   = rc4_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = rc4_pkg::CFG_DATA_W;
    localparam int LEN_W       = rc4_pkg::LEN_W;
    localparam int WORD_BYTES  = rc4_pkg::WORD_BYTES;

    localparam int MAX_KEY          = 16;
    localparam int CYCLE_LIMIT      = 8_000_000;
    localparam int PHASES           = 8;
    localparam int BEATS_PER_PHASE  = 112;
    localparam int MAX_GAP          = 20;
    localparam int DRAIN_CYCLES     = 12;
    localparam int SCRIPT_ROWS      = 24;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   value;
        logic [BYTE_W-1:0]       data;
        logic                    msg_start;
        logic                    typed;
        logic [BYTE_W-1:0]       want;
    } script_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      data_byte = '0;
    logic                   first = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BYTE_W-1:0]      result_byte;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // cipher state mirrored by the testbench
    logic [BYTE_W-1:0]      perm [TABLE_DEPTH];
    logic [BYTE_W-1:0]      pi;
    logic [BYTE_W-1:0]      pj;
    logic [LEN_W-1:0]       key_len;
    logic [CFG_DATA_W-1:0]  key_lo;
    logic [CFG_DATA_W-1:0]  key_hi;

    logic [BYTE_W-1:0]      pending_cipher [$];
    logic [BYTE_W-1:0]      head_byte;
    script_row_t            script [SCRIPT_ROWS];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int errors     = 0;
    int cycles     = 0;
    int bytes_sent = 0;
    int msg_starts = 0;
    int reg_writes = 0;

    rc4_stream_cipher_top #(
        .MAX_KEY_BYTES (MAX_KEY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .first       (first),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_byte (result_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed", cycles,
                     pending_cipher.size());
            $display("FAIL");
            $finish;
        end
    end

    // random back-pressure on the output
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // compare every output beat with the oldest predicted byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cipher.size() == 0)
            begin
                $error("result_byte: expected no beat, actual %02h", result_byte);
                errors++;
            end
            else
            begin
                head_byte = pending_cipher.pop_front();
                if (result_byte !== head_byte)
                begin
                    $error("result_byte: expected %02h, actual %02h", head_byte,
                           result_byte);
                    errors++;
                end
            end
        end
    end

    // key byte n, low word first
    function automatic logic [BYTE_W-1:0] key_at(input int n);
        logic [CFG_DATA_W-1:0] w;
        w = (n < WORD_BYTES) ? key_lo : key_hi;
        return w[(n % WORD_BYTES) * BYTE_W +: BYTE_W];
    endfunction

    // identity fill followed by the key schedule
    task automatic run_key_schedule();
        int len;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] t;
        if (key_len == 0)
            len = 1;
        else if (key_len > MAX_KEY)
            len = MAX_KEY;
        else
            len = int'(key_len);
        for (int n = 0; n < TABLE_DEPTH; n++)
            perm[n] = n[BYTE_W-1:0];
        pi  = '0;
        pj  = '0;
        acc = '0;
        for (int n = 0; n < TABLE_DEPTH; n++)
        begin
            acc     = acc + perm[n] + key_at(n % len);
            t       = perm[n];
            perm[n] = perm[acc];
            perm[acc] = t;
        end
    endtask

    // one keystream step, xor with the data byte
    task automatic crypt_byte(input logic [BYTE_W-1:0] d, input logic start,
                              output logic [BYTE_W-1:0] res);
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] s;
        if (start)
            run_key_schedule();
        pi       = pi + 8'd1;
        pj       = pj + perm[pi];
        t        = perm[pi];
        perm[pi] = perm[pj];
        perm[pj] = t;
        s        = perm[pi] + perm[pj];
        res      = d ^ perm[s];
    endtask

    // drive one input beat after a random gap, predict at accept
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic start,
                             input logic typed, input logic [BYTE_W-1:0] want);
        int gap;
        logic [BYTE_W-1:0] res;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        first     <= start;
        do
            @(posedge clk);
        while (in_stall);
        crypt_byte(d, start, res);
        pending_cipher.push_back(typed ? want : res);
        bytes_sent++;
        if (start)
            msg_starts++;
    endtask

    // stop sending and wait until every predicted byte has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_cipher.size() != 0);
    endtask

    // one register write, valid stays up when another write follows
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value, input logic hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rc4_pkg::CFG_KEY_LENGTH: key_len = value[LEN_W-1:0];
            rc4_pkg::CFG_KEY_LOW:    key_lo  = value;
            rc4_pkg::CFG_KEY_HIGH:   key_hi  = value;
            default:                 ;
        endcase
        if (!hold)
            cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    initial
    begin
        int k;
        int msg_left;
        int lens [PHASES];
        int send_idle [PHASES];
        int recv_stall [PHASES];
        logic start;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;

        lens       = '{1, 16, 0, 31, 17, 2, 15, 0};
        send_idle  = '{0, 76, 0, 25, 0, 76, 0, 25};
        recv_stall = '{0, 0, 76, 25, 0, 0, 76, 25};

        // directed rows; typed values are the reset keystream and a known test vector
        script = '{
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h00, 1'b0, 1'b1, 8'h02},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b1, 8'hFA},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h5A, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'hA5, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF,
              8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF,
              8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h3C, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'hC3, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LENGTH, 64'd16, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  CFG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h80, 1'b1, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h01, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LENGTH, 64'd17, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_HIGH, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h7F, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,  rc4_pkg::CFG_KEY_LOW, 64'h0000_0000_0079_654B,
              8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h50, 1'b1, 1'b1, 8'hBB},
            '{ROW_BYTE, rc4_pkg::CFG_KEY_LENGTH, 64'h0, 8'h6C, 1'b0, 1'b1, 8'hF3}
        };

        // mirror starts from the reset state
        for (int n = 0; n < TABLE_DEPTH; n++)
            perm[n] = n[BYTE_W-1:0];
        pi      = '0;
        pj      = '0;
        key_len = rc4_pkg::KEY_LENGTH_RESET;
        key_lo  = '0;
        key_hi  = '0;

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows, register writes only once the pipe is empty
        k = 0;
        while (k < SCRIPT_ROWS)
        begin
            if (script[k].kind == ROW_CFG)
            begin
                drain_results();
                while (k < SCRIPT_ROWS && script[k].kind == ROW_CFG)
                begin
                    write_register(script[k].idx, script[k].value,
                                   k + 1 < SCRIPT_ROWS && script[k + 1].kind == ROW_CFG);
                    k++;
                end
            end
            else
            begin
                send_byte(script[k].data, script[k].msg_start, script[k].typed,
                          script[k].want);
                k++;
            end
        end

        // random messages, new key and idle mode per phase
        msg_left = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            idle_pct  = 0;
            stall_pct = 0;
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (p == 0)
            begin
                lo = '1;
                hi = '0;
            end
            else if (p == 1)
            begin
                lo = '0;
                hi = '1;
            end
            write_register(rc4_pkg::CFG_KEY_LENGTH,
                           (p == PHASES - 1) ? 64'($urandom_range(31)) : 64'(lens[p]), 1'b1);
            write_register(rc4_pkg::CFG_KEY_LOW, lo, 1'b1);
            write_register(rc4_pkg::CFG_KEY_HIGH, hi, 1'b0);
            idle_pct  = send_idle[p];
            stall_pct = recv_stall[p];

            repeat (BEATS_PER_PHASE)
            begin
                if ($urandom_range(11) == 0)
                begin
                    // stray beat outside the message framing
                    start = 1'($urandom_range(1));
                end
                else
                begin
                    if (msg_left == 0)
                    begin
                        msg_left = ($urandom_range(19) == 0) ? int'($urandom_range(200, 300))
                                                             : int'($urandom_range(1, 24));
                        start = 1'b1;
                    end
                    else
                        start = 1'b0;
                    msg_left--;
                end
                // now and then hold off until the output side is empty
                if ($urandom_range(59) == 0)
                    drain_results();
                send_byte(8'($urandom_range(255)), start, 1'b0, 8'h00);
            end
        end

        // wind down
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d bytes in %0d message starts with %0d register writes",
                 bytes_sent, msg_starts, reg_writes);
        $display("idle modes: none, sender 76%%, receiver 76%%, both 25%%; %0d errors",
                 errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rc4_pkg.sv
sv/rc4_ram.sv
sv/rc4_stream_cipher_top.sv
tb/tb_rc4_stream_cipher_top.sv
